### hw/rtl/dchw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core heartbeat watchdog package
// Shared widths, event codes, register indexes and reset values, together
// with the configuration and result structures passed between modules.
// ----------------------------------------------------------------------------
package dchw_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Event codes carried in the op field.
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_BEAT0 = 3'd1;
    localparam logic [OP_W-1:0] OP_BEAT1 = 3'd2;
    localparam logic [OP_W-1:0] OP_START = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CORE_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HW_ENABLE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IC_ENABLE     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CFG_DAT_W-1:0] CORE_TIMEOUT_RST  = 16'd1000;
    localparam logic [CFG_DAT_W-1:0] KICK_INTERVAL_RST = 16'd100;
    localparam logic                 HW_ENABLE_RST     = 1'b1;
    localparam logic                 IC_ENABLE_RST     = 1'b1;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] core_timeout_ms;
        logic [CFG_DAT_W-1:0] kick_interval_ms;
        logic                 hardware_enable;
        logic                 inter_core_enable;
    } cfg_t;

    typedef struct packed {
        logic             kick;
        logic             reset_request;
        logic             core0_ok;
        logic             core1_ok;
        logic             healthy;
        logic             running;
        logic [CNT_W-1:0] warning_total;
        logic [CNT_W-1:0] kick_total;
        logic [CNT_W-1:0] core0_beats;
        logic [CNT_W-1:0] core1_beats;
    } result_t;

endpackage

### hw/rtl/dchw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core heartbeat watchdog configuration registers
// Holds the timeout, kick interval and the two enable bits; a write stores
// the low bits of the data up to each register's width.
// ----------------------------------------------------------------------------
module dchw_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [dchw_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [dchw_pkg::CFG_DAT_W-1:0]  wr_data,
    output dchw_pkg::cfg_t                  cfg
);

    dchw_pkg::cfg_t cfg_reg;
    dchw_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                dchw_pkg::REG_CORE_TIMEOUT:  cfg_next.core_timeout_ms   = wr_data;
                dchw_pkg::REG_KICK_INTERVAL: cfg_next.kick_interval_ms  = wr_data;
                dchw_pkg::REG_HW_ENABLE:     cfg_next.hardware_enable   = wr_data[0];
                dchw_pkg::REG_IC_ENABLE:     cfg_next.inter_core_enable = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.core_timeout_ms   <= dchw_pkg::CORE_TIMEOUT_RST;
            cfg_reg.kick_interval_ms  <= dchw_pkg::KICK_INTERVAL_RST;
            cfg_reg.hardware_enable   <= dchw_pkg::HW_ENABLE_RST;
            cfg_reg.inter_core_enable <= dchw_pkg::IC_ENABLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/dchw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core heartbeat watchdog event engine
// Applies one registered event per cycle, while advance is high, to the
// watchdog state; its registers, with the kick flag, form the result register.
// ----------------------------------------------------------------------------
module dchw_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [dchw_pkg::OP_W-1:0]     op,
    input  logic [dchw_pkg::TIME_W-1:0]   now_ms,
    input  dchw_pkg::cfg_t                cfg,
    output dchw_pkg::result_t             result
);

    logic [dchw_pkg::TIME_W-1:0] core0_stamp_reg, core0_stamp_next;
    logic [dchw_pkg::TIME_W-1:0] core1_stamp_reg, core1_stamp_next;
    logic [dchw_pkg::CNT_W-1:0]  core0_count_reg, core0_count_next;
    logic [dchw_pkg::CNT_W-1:0]  core1_count_reg, core1_count_next;
    logic [dchw_pkg::CNT_W-1:0]  warnings_reg, warnings_next;
    logic [dchw_pkg::CNT_W-1:0]  kicks_reg, kicks_next;
    logic [dchw_pkg::TIME_W-1:0] last_kick_reg, last_kick_next;
    logic [dchw_pkg::TIME_W-1:0] unhealthy_since_reg, unhealthy_since_next;
    logic core0_resp_reg, core0_resp_next;
    logic core1_resp_reg, core1_resp_next;
    logic system_ok_reg, system_ok_next;
    logic started_reg, started_next;
    logic fatal_reg, fatal_next;
    logic kick_reg, kick_next;

    logic [dchw_pkg::TIME_W-1:0] kick_age;
    logic [dchw_pkg::TIME_W-1:0] core0_age;
    logic [dchw_pkg::TIME_W-1:0] core1_age;
    logic [dchw_pkg::TIME_W-1:0] unhealthy_age;
    logic [dchw_pkg::TIME_W-1:0] timeout_ext;
    logic [dchw_pkg::TIME_W-1:0] fatal_limit;
    logic                        kick_due;
    logic                        core0_fresh;
    logic                        core1_fresh;
    logic [1:0]                  lost_count;

    // All ages are wrapping 32-bit differences.
    assign kick_age      = now_ms - last_kick_reg;
    assign core0_age     = now_ms - core0_stamp_reg;
    assign core1_age     = now_ms - core1_stamp_reg;
    assign unhealthy_age = now_ms - unhealthy_since_reg;
    assign timeout_ext   = {{(dchw_pkg::TIME_W - dchw_pkg::CFG_DAT_W){1'b0}},
                            cfg.core_timeout_ms};
    assign fatal_limit   = {timeout_ext[dchw_pkg::TIME_W-2:0], 1'b0};

    assign kick_due = cfg.hardware_enable &&
                      (kick_age >= {{(dchw_pkg::TIME_W - dchw_pkg::CFG_DAT_W){1'b0}},
                                    cfg.kick_interval_ms});
    // A stamp of zero means the core has never beaten.
    assign core0_fresh = (core0_stamp_reg != '0) && (core0_age <= timeout_ext);
    assign core1_fresh = (core1_stamp_reg != '0) && (core1_age <= timeout_ext);
    assign lost_count  = {1'b0, core0_resp_reg && !core0_fresh} +
                         {1'b0, core1_resp_reg && !core1_fresh};

    always_comb begin
        core0_stamp_next     = core0_stamp_reg;
        core1_stamp_next     = core1_stamp_reg;
        core0_count_next     = core0_count_reg;
        core1_count_next     = core1_count_reg;
        warnings_next        = warnings_reg;
        kicks_next           = kicks_reg;
        last_kick_next       = last_kick_reg;
        unhealthy_since_next = unhealthy_since_reg;
        core0_resp_next      = core0_resp_reg;
        core1_resp_next      = core1_resp_reg;
        system_ok_next       = system_ok_reg;
        started_next         = started_reg;
        fatal_next           = fatal_reg;
        kick_next            = 1'b0;

        case (op)
            dchw_pkg::OP_TICK: begin
                if (started_reg) begin
                    if (kick_due) begin
                        kick_next      = 1'b1;
                        kicks_next     = kicks_reg + 1'b1;
                        last_kick_next = now_ms;
                    end
                    if (cfg.inter_core_enable) begin
                        core0_resp_next = core0_fresh;
                        core1_resp_next = core1_fresh;
                        warnings_next   = warnings_reg +
                                          {{(dchw_pkg::CNT_W - 2){1'b0}}, lost_count};
                        system_ok_next  = core0_fresh && core1_fresh;
                        if (core0_fresh && core1_fresh) begin
                            unhealthy_since_next = '0;
                        end else if (unhealthy_since_reg == '0) begin
                            unhealthy_since_next = now_ms;
                        end else if (unhealthy_age > fatal_limit) begin
                            fatal_next = 1'b1;
                        end
                    end
                end
            end
            dchw_pkg::OP_BEAT0: begin
                core0_stamp_next = now_ms;
                core0_count_next = core0_count_reg + 1'b1;
            end
            dchw_pkg::OP_BEAT1: begin
                core1_stamp_next = now_ms;
                core1_count_next = core1_count_reg + 1'b1;
            end
            dchw_pkg::OP_START: begin
                if (!started_reg) begin
                    core0_stamp_next = now_ms;
                    core0_count_next = core0_count_reg + 2'd2;
                    last_kick_next   = now_ms;
                    started_next     = 1'b1;
                end
            end
            dchw_pkg::OP_STOP: begin
                started_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core0_stamp_reg     <= '0;
            core1_stamp_reg     <= '0;
            core0_count_reg     <= '0;
            core1_count_reg     <= '0;
            warnings_reg        <= '0;
            kicks_reg           <= '0;
            last_kick_reg       <= '0;
            unhealthy_since_reg <= '0;
            core0_resp_reg      <= 1'b0;
            core1_resp_reg      <= 1'b0;
            system_ok_reg       <= 1'b0;
            started_reg         <= 1'b0;
            fatal_reg           <= 1'b0;
            kick_reg            <= 1'b0;
        end else if (advance) begin
            core0_stamp_reg     <= core0_stamp_next;
            core1_stamp_reg     <= core1_stamp_next;
            core0_count_reg     <= core0_count_next;
            core1_count_reg     <= core1_count_next;
            warnings_reg        <= warnings_next;
            kicks_reg           <= kicks_next;
            last_kick_reg       <= last_kick_next;
            unhealthy_since_reg <= unhealthy_since_next;
            core0_resp_reg      <= core0_resp_next;
            core1_resp_reg      <= core1_resp_next;
            system_ok_reg       <= system_ok_next;
            started_reg         <= started_next;
            fatal_reg           <= fatal_next;
            kick_reg            <= kick_next;
        end
    end

    assign result.kick          = kick_reg;
    assign result.reset_request = fatal_reg;
    assign result.core0_ok      = core0_resp_reg;
    assign result.core1_ok      = core1_resp_reg;
    assign result.healthy       = system_ok_reg;
    assign result.running       = started_reg;
    assign result.warning_total = warnings_reg;
    assign result.kick_total    = kicks_reg;
    assign result.core0_beats   = core0_count_reg;
    assign result.core1_beats   = core1_count_reg;

endmodule

### hw/rtl/dual_core_heartbeat_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core heartbeat watchdog
// Watches two cores through timestamped heartbeat events, kicks a hardware
// watchdog on ticks and latches a reset request after prolonged ill health.
// ----------------------------------------------------------------------------
// The block takes one event request per clock cycle while s_ready is high
// and returns exactly one result request for each, in order. An accepted
// event is held in the input register and is applied to the watchdog state
// once the result slot is free or being emptied, and its result is then
// offered from the output register. The throughput is one event per cycle,
// limited only by the single update of the state registers; it falls only when the
// result side stalls. The result fields show the state after the event;
// kick is 1 only for a tick that kicked the hardware watchdog. Configuration
// writes are always accepted and take effect on the next event; they should
// be made while no event is in flight.
// ----------------------------------------------------------------------------
module dual_core_heartbeat_watchdog (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dchw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dchw_pkg::CFG_DAT_W-1:0]  cfg_data,

    // Event channel.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dchw_pkg::OP_W-1:0]       s_op,
    input  logic [dchw_pkg::TIME_W-1:0]     s_now_ms,

    // Result channel.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kick,
    output logic                            m_reset_request,
    output logic                            m_core0_ok,
    output logic                            m_core1_ok,
    output logic                            m_healthy,
    output logic                            m_running,
    output logic [dchw_pkg::CNT_W-1:0]      m_warning_total,
    output logic [dchw_pkg::CNT_W-1:0]      m_kick_total,
    output logic [dchw_pkg::CNT_W-1:0]      m_core0_beats,
    output logic [dchw_pkg::CNT_W-1:0]      m_core1_beats
);

    dchw_pkg::cfg_t    cfg;
    dchw_pkg::result_t result;

    logic                        in_valid_reg, in_valid_next;
    logic [dchw_pkg::OP_W-1:0]   in_op_reg;
    logic [dchw_pkg::TIME_W-1:0] in_now_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        advance;
    logic                        s_accept;

    // The configuration registers can take a write in every cycle.
    assign cfg_ready = 1'b1;

    dchw_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The registered event moves into the state when the result slot is free
    // or is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The event payload needs no reset; it is only used while marked valid.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg  <= s_op;
            in_now_reg <= s_now_ms;
        end
    end

    dchw_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .op      (in_op_reg),
        .now_ms  (in_now_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // The state only changes on an advance, so the fields hold steady while
    // a result waits to be taken.
    assign m_valid         = out_valid_reg;
    assign m_kick          = result.kick;
    assign m_reset_request = result.reset_request;
    assign m_core0_ok      = result.core0_ok;
    assign m_core1_ok      = result.core1_ok;
    assign m_healthy       = result.healthy;
    assign m_running       = result.running;
    assign m_warning_total = result.warning_total;
    assign m_kick_total    = result.kick_total;
    assign m_core0_beats   = result.core0_beats;
    assign m_core1_beats   = result.core1_beats;

endmodule
